### design/upr_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger package
// Shared types and constants for the ping ranger: phase codes, the beat
// records passed down the result pipeline and the distance scaling constants.
// ----------------------------------------------------------------------------
package upr_pkg;

  // Ping machine phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BURST = 2'd1,
    PH_ECHO  = 2'd2
  } upr_phase_t;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 24;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned FLIGHT_W   = 22;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 24'd60000;
  localparam logic [TIME_W-1:0]     TRIG_HOLD_US = 32'd1000;
  localparam logic [DIST_W-1:0]     DIST_MAX     = 16'hFFFF;

  // distance = floor(343 * flight / 20000); saturates from this flight upwards
  localparam logic [TIME_W-1:0] FLIGHT_SAT_MIN = 32'd3821342;

  // Reciprocal of 20000 scaled by 343 and 2^DIST_SHIFT, rounded up; exact for
  // every flight below FLIGHT_SAT_MIN
  localparam int unsigned DIST_SHIFT = 37;
  localparam int unsigned PROD_W     = FLIGHT_W + 32;
  localparam logic [63:0] DIST_RECIP_WIDE =
      ((64'd343 << DIST_SHIFT) + 64'd19999) / 64'd20000;
  localparam logic [31:0] DIST_RECIP = DIST_RECIP_WIDE[31:0];

  // Result of the control step for one poll
  typedef struct packed {
    logic                trigger;
    upr_phase_t          phase;
    logic                fresh;
    logic                sat;
    logic [FLIGHT_W-1:0] flight;
  } upr_ping_t;

  // Poll record after the scaling multiply
  typedef struct packed {
    logic              trigger;
    upr_phase_t        phase;
    logic              fresh;
    logic              sat;
    logic [DIST_W-1:0] dist_cm;
  } upr_dist_t;

endpackage

### design/upr_if.sv
// ----------------------------------------------------------------------------
// Ping ranger stream interfaces
// Valid/ready channels for poll beats in and result beats out.
// ----------------------------------------------------------------------------
interface upr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_us;
  logic        echo_level;

  modport source (output valid, time_us, echo_level, input ready);
  modport sink   (input valid, time_us, echo_level, output ready);
endinterface

interface upr_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic [15:0] range_cm;
  logic        new_distance;
  logic [1:0]  ping_phase;

  modport source (output valid, trigger_level, range_cm, new_distance, ping_phase,
                  input ready);
  modport sink   (input valid, trigger_level, range_cm, new_distance, ping_phase,
                  output ready);
endinterface

### design/upr_ctrl.sv
// ----------------------------------------------------------------------------
// Ping ranger control
// Ping state machine, echo timing, trigger drive and the next ping schedule.
// State advances once for every accepted poll beat.
// ----------------------------------------------------------------------------
module upr_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                poll_en,
  input  logic [upr_pkg::TIME_W-1:0]          now,
  input  logic                                echo,
  input  logic                                cfg_we,
  input  logic [upr_pkg::INTERVAL_W-1:0]      cfg_wdata,
  output upr_pkg::upr_ping_t                  ping
);

  upr_pkg::upr_phase_t                 phase_r, phase_nxt;
  logic                                echo_prev_r, echo_prev_nxt;
  logic [upr_pkg::TIME_W-1:0]          start_r, start_nxt;
  logic [upr_pkg::TIME_W-1:0]          next_ping_r, next_ping_nxt;
  logic                                trig_r, trig_nxt;
  logic [upr_pkg::INTERVAL_W-1:0]      interval_r;
  logic [upr_pkg::TIME_W-1:0]          flight;
  logic                                fresh;

  // Hold the interval register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= upr_pkg::INTERVAL_RST;
    end else if (cfg_we) begin
      interval_r <= cfg_wdata;
    end
  end

  // Advance the ping state on each poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= upr_pkg::PH_IDLE;
      echo_prev_r <= 1'b0;
      start_r     <= '0;
      next_ping_r <= '0;
      trig_r      <= 1'b1;
    end else if (poll_en) begin
      phase_r     <= phase_nxt;
      echo_prev_r <= echo_prev_nxt;
      start_r     <= start_nxt;
      next_ping_r <= next_ping_nxt;
      trig_r      <= trig_nxt;
    end
  end

  // Measure, then release, then fire
  always_comb begin
    phase_nxt     = phase_r;
    echo_prev_nxt = echo_prev_r;
    start_nxt     = start_r;
    next_ping_nxt = next_ping_r;
    trig_nxt      = trig_r;
    fresh         = 1'b0;
    flight        = now - start_r;

    if (phase_r != upr_pkg::PH_IDLE) begin
      if (phase_r == upr_pkg::PH_BURST && !echo_prev_r && echo) begin
        start_nxt = now;
        phase_nxt = upr_pkg::PH_ECHO;
      end else if (phase_r == upr_pkg::PH_ECHO && echo_prev_r && !echo) begin
        phase_nxt = upr_pkg::PH_IDLE;
        if (now > start_r) begin
          fresh         = 1'b1;
          next_ping_nxt = now + {{(upr_pkg::TIME_W-upr_pkg::INTERVAL_W){1'b0}}, interval_r};
        end
      end
      echo_prev_nxt = echo;
    end

    // release the trigger after the hold time
    if ((start_nxt + upr_pkg::TRIG_HOLD_US) < now && !trig_r) begin
      trig_nxt = 1'b1;
    end

    // fire a new ping once the schedule has passed
    if (phase_nxt == upr_pkg::PH_IDLE && next_ping_nxt < now) begin
      trig_nxt  = 1'b0;
      phase_nxt = upr_pkg::PH_BURST;
    end
  end

  // Hand the poll outcome to the result pipeline
  always_comb begin
    ping.trigger = trig_nxt;
    ping.phase   = phase_nxt;
    ping.fresh   = fresh;
    ping.sat     = (flight >= upr_pkg::FLIGHT_SAT_MIN);
    ping.flight  = flight[upr_pkg::FLIGHT_W-1:0];
  end

endmodule

### design/ultrasonic_ping_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger
// Time-of-flight ranger driven by periodic polls of time and echo level.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one poll beat per tick carrying time_us and echo_level.
//   out_bus : one result beat per poll: trigger drive, last distance in cm,
//             a flag for a newly completed measurement and the ping phase.
//   cfg_we / cfg_wdata : write the 24-bit measurement interval in us; write
//             only while no poll is in flight.
//   The control state updates in the cycle a poll is accepted. The result
//   then passes a flight register, the scaling multiply register and the
//   output register on its way to out_bus.valid. Throughput is one poll
//   per cycle unless the receiver stalls while all stages are full.
//   Each stage moves on when the next one is empty or moving, so polls are
//   taken while a finished result waits for out_bus.ready; in_bus.ready drops
//   only when all three stages are full and the receiver stalls.
//   Reset empties the pipeline, sets the machine idle with the trigger
//   released, zeroes distance and schedule and loads the interval 60000 us.
// ----------------------------------------------------------------------------
module ultrasonic_ping_ranger (
  input  logic                               clk,
  input  logic                               rst_n,
  upr_in_if.sink                             in_bus,
  upr_out_if.source                          out_bus,
  input  logic                               cfg_we,
  input  logic [upr_pkg::INTERVAL_W-1:0]     cfg_wdata
);

  upr_pkg::upr_ping_t              ping;
  upr_pkg::upr_ping_t              s1_r;
  upr_pkg::upr_dist_t              s2_r, s2_nxt;
  logic                            v1_r, v2_r, v3_r;
  logic                            trig_out_r, fresh_out_r;
  upr_pkg::upr_phase_t             phase_out_r;
  logic [upr_pkg::DIST_W-1:0]      last_dist_r, last_dist_nxt;
  logic [upr_pkg::PROD_W-1:0]      prod;
  logic                            accept, load2, load3;

  // Stage handshake
  assign load3  = v2_r && (!v3_r || out_bus.ready);
  assign load2  = v1_r && (!v2_r || load3);
  assign in_bus.ready = !v1_r || load2;
  assign accept = in_bus.valid && in_bus.ready;

  upr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .poll_en   (accept),
    .now       (in_bus.time_us),
    .echo      (in_bus.echo_level),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ping      (ping)
  );

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept || (v1_r && !load2);
      v2_r <= load2 || (v2_r && !load3);
      v3_r <= load3 || (v3_r && !out_bus.ready);
    end
  end

  // Hold the poll outcome
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= ping;
    end
  end

  // Scale flight to centimetres
  always_comb begin
    prod           = upr_pkg::PROD_W'(s1_r.flight) * upr_pkg::PROD_W'(upr_pkg::DIST_RECIP);
    s2_nxt.trigger = s1_r.trigger;
    s2_nxt.phase   = s1_r.phase;
    s2_nxt.fresh   = s1_r.fresh;
    s2_nxt.sat     = s1_r.sat;
    s2_nxt.dist_cm = prod[upr_pkg::DIST_SHIFT +: upr_pkg::DIST_W];
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_r <= s2_nxt;
    end
  end

  // Keep the last distance, saturated
  always_comb begin
    last_dist_nxt = last_dist_r;
    if (s2_r.fresh) begin
      last_dist_nxt = s2_r.sat ? upr_pkg::DIST_MAX : s2_r.dist_cm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= '0;
    end else if (load3) begin
      last_dist_r <= last_dist_nxt;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (load3) begin
      trig_out_r  <= s2_r.trigger;
      fresh_out_r <= s2_r.fresh;
      phase_out_r <= s2_r.phase;
    end
  end

  assign out_bus.valid         = v3_r;
  assign out_bus.trigger_level = trig_out_r;
  assign out_bus.range_cm      = last_dist_r;
  assign out_bus.new_distance  = fresh_out_r;
  assign out_bus.ping_phase    = phase_out_r;

endmodule

### test/ultrasonic_ping_ranger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger testbench
// Sends poll beats (time and echo level) to the ranger and checks every result
// beat against a cycle-free model of the ping machine: trigger drive, last
// distance, new-measurement flag and phase. A directed opening covers the
// boundary cases; well-formed random pings with some noise follow, under
// several interval settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module ultrasonic_ping_ranger_test;

  localparam int unsigned SPEED_NUM   = 343;
  localparam int unsigned SPEED_DEN   = 10000;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_POLLS = 175;

  typedef struct packed {
    logic [upr_pkg::TIME_W-1:0] now;
    logic                       echo;
  } poll_t;

  typedef struct packed {
    logic                       trigger;
    logic [upr_pkg::DIST_W-1:0] dist_cm;
    logic                       fresh;
    upr_pkg::upr_phase_t        phase;
  } reading_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [upr_pkg::INTERVAL_W-1:0] cfg_wdata;

  upr_in_if  in_bus ();
  upr_out_if out_bus ();

  ultrasonic_ping_ranger DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  poll_t    polls_to_send[$];
  reading_t readings_due[$];
  int unsigned fault_count = 0;
  int unsigned polls_added = 0;
  int unsigned quiet_cycles = 0;
  logic [upr_pkg::TIME_W-1:0] clock_us;

  // Model state of the ping machine
  upr_pkg::upr_phase_t            st_phase;
  logic                           st_echo;
  logic [upr_pkg::TIME_W-1:0]     st_start;
  logic [upr_pkg::TIME_W-1:0]     st_due;
  logic                           st_trig;
  logic [upr_pkg::DIST_W-1:0]     st_dist;
  logic [upr_pkg::INTERVAL_W-1:0] st_interval;

  // Advance the model by one poll and return the reading it produces
  function automatic reading_t range_poll(logic [upr_pkg::TIME_W-1:0] now, logic echo);
    reading_t   r;
    logic [63:0] flight;
    logic [63:0] cm;
    r.fresh = 1'b0;
    // measure
    if (st_phase != upr_pkg::PH_IDLE) begin
      if (st_phase == upr_pkg::PH_BURST && !st_echo && echo) begin
        st_start = now;
        st_phase = upr_pkg::PH_ECHO;
      end else if (st_phase == upr_pkg::PH_ECHO && st_echo && !echo) begin
        st_phase = upr_pkg::PH_IDLE;
        if (now > st_start) begin
          flight  = {32'd0, now - st_start};
          cm      = (64'(SPEED_NUM) * flight / 64'(SPEED_DEN)) / 64'd2;
          st_dist = (cm > 64'(upr_pkg::DIST_MAX)) ? upr_pkg::DIST_MAX
                                                  : cm[upr_pkg::DIST_W-1:0];
          st_due  = now + {{(upr_pkg::TIME_W-upr_pkg::INTERVAL_W){1'b0}}, st_interval};
          r.fresh = 1'b1;
        end
      end
      st_echo = echo;
    end
    // release trigger
    if (st_start + upr_pkg::TRIG_HOLD_US < now && !st_trig)
      st_trig = 1'b1;
    // fire trigger
    if (st_phase == upr_pkg::PH_IDLE && st_due < now) begin
      st_trig  = 1'b0;
      st_phase = upr_pkg::PH_BURST;
    end
    r.trigger = st_trig;
    r.dist_cm = st_dist;
    r.phase   = st_phase;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  // Poll driver
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  always @(posedge clk) begin : poll_driver
    poll_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        readings_due.push_back(range_poll(in_bus.time_us, in_bus.echo_level));
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (polls_to_send.size() > 0) begin
          nxt = polls_to_send.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.time_us    <= nxt.now;
          in_bus.echo_level <= nxt.echo;
          if (send_calm > 0)
            send_calm--;
          else if ($urandom_range(0, 49) == 0)
            send_calm = $urandom_range(20, 80);
          else
            send_gap = pause_len();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest reading due
  int unsigned recv_hold = 0;
  int unsigned recv_calm = 0;
  always @(posedge clk) begin : result_monitor
    reading_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (readings_due.size() == 0) begin
          $error("result beat with no reading due");
          fault_count++;
        end else begin
          want = readings_due.pop_front();
          if (out_bus.trigger_level !== want.trigger) begin
            $error("trigger_level: expected %0d, got %0d", want.trigger, out_bus.trigger_level);
            fault_count++;
          end
          if (out_bus.range_cm !== want.dist_cm) begin
            $error("range_cm: expected %0d, got %0d", want.dist_cm, out_bus.range_cm);
            fault_count++;
          end
          if (out_bus.new_distance !== want.fresh) begin
            $error("new_distance: expected %0d, got %0d", want.fresh, out_bus.new_distance);
            fault_count++;
          end
          if (out_bus.ping_phase !== want.phase) begin
            $error("ping_phase: expected %0d, got %0d", want.phase, out_bus.ping_phase);
            fault_count++;
          end
        end
      end
      // stall the receiver at random
      if (recv_hold > 0) begin
        recv_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (recv_calm > 0)
          recv_calm--;
        else if ($urandom_range(0, 49) == 0)
          recv_calm = $urandom_range(20, 80);
        else if ($urandom_range(0, 2) == 0)
          recv_hold = pause_len();
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_poll(logic [upr_pkg::TIME_W-1:0] now, logic echo);
    poll_t p;
    p.now  = now;
    p.echo = echo;
    polls_to_send.push_back(p);
    polls_added++;
  endtask

  // Hold until every poll has gone out and every reading has come back
  task automatic drain();
    do @(negedge clk);
    while (polls_to_send.size() != 0 || in_bus.valid || readings_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_interval(logic [upr_pkg::INTERVAL_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    st_interval  = value;
  endtask

  // One ping: wait out the schedule, rising edge, echo held for a flight,
  // falling edge, a few quiet polls
  task automatic ping_sequence();
    logic [upr_pkg::TIME_W-1:0] start;
    logic [upr_pkg::TIME_W-1:0] flight;
    logic [upr_pkg::TIME_W-1:0] step;
    int unsigned kind;
    int unsigned n_high;
    clock_us = clock_us + {{(upr_pkg::TIME_W-upr_pkg::INTERVAL_W){1'b0}}, st_interval}
               + $urandom_range(1, 40);
    add_poll(clock_us, 1'b0);
    repeat ($urandom_range(0, 3)) begin
      clock_us = clock_us + $urandom_range(1, 200);
      add_poll(clock_us, 1'b0);
    end
    clock_us = clock_us + $urandom_range(1, 200);
    start    = clock_us;
    add_poll(start, 1'b1);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: flight = $urandom_range(1, 3000);
      4, 5, 6:    flight = $urandom_range(3001, 1000000);
      7:          flight = $urandom_range(3821330, 3821354);
      8:          flight = $urandom_range(3821355, 32'hFFFF_FFFF);
      default:    flight = 0;
    endcase
    n_high = $urandom_range(0, 4);
    step   = flight / (n_high + 1);
    repeat (n_high) begin
      clock_us = clock_us + step;
      add_poll(clock_us, 1'b1);
    end
    // an end at or before the start must not count as a measurement
    if (kind == 9)
      clock_us = start - $urandom_range(0, 500);
    else
      clock_us = start + flight;
    add_poll(clock_us, 1'b0);
    repeat ($urandom_range(0, 2)) begin
      clock_us = clock_us + $urandom_range(1, 2000);
      add_poll(clock_us, 1'b0);
    end
  endtask

  // Noise: echo bounce near the cursor, or polls at arbitrary times
  task automatic noise_sequence();
    logic [upr_pkg::TIME_W-1:0] t;
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        clock_us = clock_us + $urandom_range(0, 3000);
        add_poll(clock_us, 1'($urandom_range(0, 1)));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        t = $urandom;
        add_poll(t, 1'($urandom_range(0, 1)));
        clock_us = t;
      end
    end
  endtask

  task automatic random_phase();
    int unsigned goal;
    goal = polls_added + PHASE_POLLS;
    while (polls_added < goal) begin
      if ($urandom_range(0, 99) < 85)
        ping_sequence();
      else
        noise_sequence();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.time_us    = '0;
    in_bus.echo_level = 1'b0;
    out_bus.ready     = 1'b0;

    st_phase    = upr_pkg::PH_IDLE;
    st_echo     = 1'b0;
    st_start    = '0;
    st_due      = '0;
    st_trig     = 1'b1;
    st_dist     = '0;
    st_interval = upr_pkg::INTERVAL_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset interval
    add_poll(32'd0, 1'b1);          // echo while idle is ignored
    add_poll(32'd1, 1'b0);          // schedule passed: fire
    add_poll(32'd2, 1'b1);          // rising edge starts timing
    add_poll(32'd3821344, 1'b0);    // first saturating flight
    add_poll(32'd3881344, 1'b0);    // schedule reached but not passed
    add_poll(32'd3881345, 1'b1);    // fire; echo in the idle poll not stored
    add_poll(32'd3881346, 1'b1);    // rising edge against the old level
    add_poll(32'd3881340, 1'b0);    // end before start
    add_poll(32'd3881400, 1'b0);    // fire on the kept schedule
    add_poll(32'd3881401, 1'b1);
    add_poll(32'd3881401, 1'b0);    // end equal to start, then fire at once
    add_poll(32'd3882500, 1'b1);
    add_poll(32'd3882600, 1'b1);
    add_poll(32'hFFFF_FFFF, 1'b0);  // huge flight; schedule wraps
    add_poll(32'hFFFF_FFFF, 1'b1);  // trigger release sum wraps
    add_poll(32'd0, 1'b0);          // end before start across the wrap
    add_poll(32'd60000, 1'b0);
    add_poll(32'd60001, 1'b1);
    add_poll(32'd60002, 1'b0);      // shortest flight, zero distance
    add_poll(32'd120003, 1'b0);
    add_poll(32'd120004, 1'b1);
    add_poll(32'd3941345, 1'b0);    // longest flight below saturation
    add_poll(32'd3941346, 1'b0);
    add_poll(32'd4001346, 1'b1);
    clock_us = 32'd4001346;
    drain();

    set_interval('0);
    random_phase();
    drain();
    set_interval({upr_pkg::INTERVAL_W{1'b1}});
    random_phase();
    drain();
    set_interval(24'd1);
    random_phase();
    drain();
    set_interval(upr_pkg::INTERVAL_W'($urandom_range(2, 5000)));
    random_phase();
    drain();
    set_interval(upr_pkg::INTERVAL_W'($urandom));
    random_phase();
    drain();
    set_interval(upr_pkg::INTERVAL_RST);
    random_phase();
    drain();

    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
design/upr_pkg.sv
design/upr_if.sv
design/upr_ctrl.sv
design/ultrasonic_ping_ranger.sv
test/ultrasonic_ping_ranger_test.sv
